// ----- rtl/core/ssba_pkg.sv -----
// ----------------------------------------------------------------------------
// Swap slot bitmap allocator package
// Shared codes, field widths and types of the allocator datapath.
// ----------------------------------------------------------------------------
package ssba_pkg;

    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 10;
    localparam int SECTOR_W = 13;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;

    localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET = 11'd1024;

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FREE    = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOC = 2'd3;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_RELEASE,
        OP_RANGE
    } op_class_t;

    typedef struct packed {
        op_class_t            op_class;
        logic [INDEX_W-1:0]   slot_index;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC,
        ST_REL,
        ST_DONE
    } back_state_t;

endpackage

// ----- rtl/core/ssba_front.sv -----
// ----------------------------------------------------------------------------
// Swap slot allocator front end
// Accepts request transactions, drops unused kinds and classifies the rest
// as allocate, release or out-of-range before queueing them.
// ----------------------------------------------------------------------------
module ssba_front #(
    parameter int CNT_W = 11
) (
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ssba_pkg::KIND_W-1:0]   s_kind,
    input  logic [ssba_pkg::INDEX_W-1:0]  s_slot_index,
    input  logic [CNT_W-1:0]              active_count,
    input  logic                          clearing,
    input  ssba_pkg::q_status_t           q_status,
    output logic                          push,
    output ssba_pkg::op_t                 push_data
);
    import ssba_pkg::*;

    localparam int CW = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    logic in_range;
    logic accept;

    assign s_ready  = !q_status.full && !clearing;
    assign accept   = s_valid && s_ready;
    assign in_range = CW'(s_slot_index) < CW'(active_count);

    always_comb begin
        push                 = 1'b0;
        push_data.op_class   = OP_ALLOC;
        push_data.slot_index = s_slot_index;
        case (s_kind)
            KIND_ALLOC: begin
                push = accept;
            end
            KIND_RELEASE, KIND_FREE: begin
                push               = accept;
                push_data.op_class = in_range ? OP_RELEASE : OP_RANGE;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/core/ssba_queue.sv -----
// ----------------------------------------------------------------------------
// Swap slot allocator request queue
// Two-entry queue of classified requests between the front and back ends.
// ----------------------------------------------------------------------------
module ssba_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ssba_pkg::op_t       push_data,
    input  logic                pop,
    output ssba_pkg::op_t       pop_data,
    output ssba_pkg::q_status_t q_status
);
    import ssba_pkg::*;

    op_t        entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       do_push;
    logic       do_pop;

    assign q_status.full  = fill_reg == 2'd2;
    assign q_status.empty = fill_reg == 2'd0;
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign pop_data       = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/ssba_back.sv -----
// ----------------------------------------------------------------------------
// Swap slot allocator back end
// Holds the free map in a word-wide memory, clears it after reset, scans it
// first fit for allocations, updates it on release and registers results.
// ----------------------------------------------------------------------------
module ssba_back #(
    parameter int SLOTS            = 1024,
    parameter int SECTORS_PER_SLOT = 8,
    parameter int CNT_W            = 11
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [CNT_W-1:0]                active_count,
    input  ssba_pkg::q_status_t             q_status,
    input  ssba_pkg::op_t                   pop_data,
    output logic                            pop,
    output logic                            clearing,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ssba_pkg::INDEX_W-1:0]    m_slot_number,
    output logic [ssba_pkg::SECTOR_W-1:0]   m_first_sector,
    output logic [ssba_pkg::STATUS_W-1:0]   m_status
);
    import ssba_pkg::*;

    localparam int WORDS   = (SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SLOT_W  = WADDR_W + BIT_W;
    localparam int RES_W   = (SLOT_W > INDEX_W) ? SLOT_W : INDEX_W;
    localparam int SPS_W   = $clog2(SECTORS_PER_SLOT + 1);
    localparam int PROD_W  = (RES_W + SPS_W > SECTOR_W) ? RES_W + SPS_W : SECTOR_W;

    logic [WORD_BITS-1:0] map_mem [WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_en;
    logic [WADDR_W-1:0]   rd_addr;
    logic                 wr_en;
    logic [WADDR_W-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    back_state_t          state_reg;
    back_state_t          state_next;
    op_t                  op_reg;
    op_t                  op_next;
    logic [WADDR_W-1:0]   scan_reg;
    logic [WADDR_W-1:0]   scan_next;
    logic [WADDR_W-1:0]   hint_reg;
    logic [WADDR_W-1:0]   hint_next;
    logic [WADDR_W-1:0]   clr_reg;
    logic [WADDR_W-1:0]   clr_next;
    logic [RES_W-1:0]     pend_slot_reg;
    logic [RES_W-1:0]     pend_slot_next;
    logic [STATUS_W-1:0]  pend_status_reg;
    logic [STATUS_W-1:0]  pend_status_next;
    logic                 pend_zero_reg;
    logic                 pend_zero_next;

    logic                 m_valid_reg;
    logic [INDEX_W-1:0]   m_slot_number_reg;
    logic [SECTOR_W-1:0]  m_first_sector_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic                 out_load;

    logic [SLOT_W:0]      act_ext;
    logic [WADDR_W:0]     act_word;
    logic [BIT_W-1:0]     act_bit;
    logic [WADDR_W:0]     words_need;
    logic                 hint_full;
    logic                 scan_last;
    logic [WORD_BITS-1:0] scan_mask;
    logic [WORD_BITS-1:0] masked;
    logic [BIT_W-1:0]     first_bit;
    logic [SLOT_W-1:0]    head_slot;
    logic [SLOT_W-1:0]    op_slot;
    logic [WADDR_W-1:0]   op_word;
    logic [BIT_W-1:0]     op_bit;
    logic [PROD_W-1:0]    sector_prod;

    assign act_ext    = (SLOT_W + 1)'(active_count);
    assign act_word   = act_ext[SLOT_W:BIT_W];
    assign act_bit    = act_ext[BIT_W-1:0];
    assign words_need = act_word + (WADDR_W + 1)'(act_bit != '0);
    assign hint_full  = {1'b0, hint_reg} >= words_need;
    assign scan_last  = ({1'b0, scan_reg} + (WADDR_W + 1)'(1)) >= words_need;
    assign head_slot  = SLOT_W'(pop_data.slot_index);
    assign op_slot    = SLOT_W'(op_reg.slot_index);
    assign op_word    = op_slot[SLOT_W-1:BIT_W];
    assign op_bit     = op_slot[BIT_W-1:0];
    assign clearing   = state_reg == ST_CLEAR;
    assign out_load   = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        if ({1'b0, scan_reg} < act_word) begin
            scan_mask = '1;
        end else if ({1'b0, scan_reg} == act_word) begin
            scan_mask = (WORD_BITS'(1) << act_bit) - WORD_BITS'(1);
        end else begin
            scan_mask = '0;
        end
        masked = rd_data_reg & scan_mask;
    end

    always_comb begin
        first_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (masked[i]) begin
                first_bit = BIT_W'(i);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == WADDR_W'(WORDS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!q_status.empty) begin
                    case (pop_data.op_class)
                        OP_ALLOC:   state_next = hint_full ? ST_DONE : ST_ALLOC;
                        OP_RELEASE: state_next = ST_REL;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_ALLOC: begin
                if (masked != '0 || scan_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_REL: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        pop              = 1'b0;
        rd_en            = 1'b0;
        rd_addr          = scan_reg;
        wr_en            = 1'b0;
        wr_addr          = scan_reg;
        wr_data          = rd_data_reg;
        op_next          = op_reg;
        scan_next        = scan_reg;
        hint_next        = hint_reg;
        clr_next         = clr_reg;
        pend_slot_next   = pend_slot_reg;
        pend_status_next = pend_status_reg;
        pend_zero_next   = pend_zero_reg;
        case (state_reg)
            ST_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '1;
                clr_next = clr_reg + WADDR_W'(1);
            end
            ST_IDLE: begin
                if (!q_status.empty) begin
                    pop     = 1'b1;
                    op_next = pop_data;
                    case (pop_data.op_class)
                        OP_ALLOC: begin
                            pend_slot_next   = '0;
                            pend_status_next = STATUS_FULL;
                            pend_zero_next   = 1'b1;
                            if (!hint_full) begin
                                rd_en     = 1'b1;
                                rd_addr   = hint_reg;
                                scan_next = hint_reg;
                            end
                        end
                        OP_RELEASE: begin
                            rd_en   = 1'b1;
                            rd_addr = head_slot[SLOT_W-1:BIT_W];
                        end
                        default: begin
                            pend_slot_next   = RES_W'(pop_data.slot_index);
                            pend_status_next = STATUS_RANGE;
                            pend_zero_next   = 1'b1;
                        end
                    endcase
                end
            end
            ST_ALLOC: begin
                if (masked != '0) begin
                    wr_en            = 1'b1;
                    wr_addr          = scan_reg;
                    wr_data          = rd_data_reg & ~(WORD_BITS'(1) << first_bit);
                    hint_next        = scan_reg;
                    pend_slot_next   = RES_W'({scan_reg, first_bit});
                    pend_status_next = STATUS_OK;
                    pend_zero_next   = 1'b0;
                end else if (!scan_last) begin
                    rd_en     = 1'b1;
                    rd_addr   = scan_reg + WADDR_W'(1);
                    scan_next = scan_reg + WADDR_W'(1);
                end
            end
            ST_REL: begin
                pend_slot_next = RES_W'(op_reg.slot_index);
                pend_zero_next = 1'b0;
                if (rd_data_reg[op_bit]) begin
                    pend_status_next = STATUS_NOT_ALLOC;
                end else begin
                    wr_en            = 1'b1;
                    wr_addr          = op_word;
                    wr_data          = rd_data_reg | (WORD_BITS'(1) << op_bit);
                    pend_status_next = STATUS_OK;
                    if (op_word < hint_reg) begin
                        hint_next = op_word;
                    end
                end
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            hint_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            hint_reg  <= hint_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        scan_reg        <= scan_next;
        pend_slot_reg   <= pend_slot_next;
        pend_status_reg <= pend_status_next;
        pend_zero_reg   <= pend_zero_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            map_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    assign sector_prod = PROD_W'(pend_slot_reg) * PROD_W'(SECTORS_PER_SLOT);

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_slot_number_reg  <= pend_slot_reg[INDEX_W-1:0];
            m_first_sector_reg <= pend_zero_reg ? '0 : sector_prod[SECTOR_W-1:0];
            m_status_reg       <= pend_status_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_slot_number  = m_slot_number_reg;
    assign m_first_sector = m_first_sector_reg;
    assign m_status       = m_status_reg;

    a_alloc_takes_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ALLOC && wr_en) |->
            ($countones(wr_data) + 1 == $countones(rd_data_reg)))
        else $error("allocation did not clear exactly one free bit");

    a_release_adds_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REL && wr_en) |->
            ($countones(wr_data) == $countones(rd_data_reg) + 1))
        else $error("release did not set exactly one free bit");

    a_hint_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        hint_reg <= WADDR_W'(WORDS - 1))
        else $error("search hint points beyond the free map");

    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (!rd_en && !pop && !m_valid_reg))
        else $error("activity during the free map clearing pass");

endmodule

// ----- rtl/core/swap_slot_bitmap_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// Swap slot bitmap allocator
// First-fit allocator of page-sized swap slots over a bitmap of free flags.
// ----------------------------------------------------------------------------
// Each accepted request waits in a two-entry queue and the back end pops it. Releases and frees
// read the map word and, if the slot was allocated, write it back before the result register
// loads; out-of-range requests and allocations into a map already known to be full go straight
// to the result, and other allocations scan one 32-slot word of the map after another from the
// search hint. The queue keeps accepting requests while the back end is busy, until it is full.
// The slot count resets to 1024, and a clearing pass after reset marks every slot free, accepting nothing.
module swap_slot_bitmap_allocator_unit #(
    parameter int SLOTS            = 1024,
    parameter int SECTORS_PER_SLOT = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ssba_pkg::COUNT_W-1:0]    cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ssba_pkg::KIND_W-1:0]     s_kind,
    input  logic [ssba_pkg::INDEX_W-1:0]    s_slot_index,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ssba_pkg::INDEX_W-1:0]    m_slot_number,
    output logic [ssba_pkg::SECTOR_W-1:0]   m_first_sector,
    output logic [ssba_pkg::STATUS_W-1:0]   m_status
);
    import ssba_pkg::*;

    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    logic [COUNT_W-1:0] slot_count_reg;
    logic [CW-1:0]      count_wide;
    logic [CNT_W-1:0]   active_count;
    logic               clearing;
    logic               push;
    logic               pop;
    op_t                push_data;
    op_t                pop_data;
    q_status_t          q_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg <= SLOT_COUNT_RESET;
        end else if (cfg_wr_en) begin
            slot_count_reg <= cfg_wr_data;
        end
    end

    assign count_wide   = (CW'(slot_count_reg) > CW'(SLOTS)) ? CW'(SLOTS)
                                                             : CW'(slot_count_reg);
    assign active_count = count_wide[CNT_W-1:0];

    ssba_front #(
        .CNT_W (CNT_W)
    ) u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_slot_index (s_slot_index),
        .active_count (active_count),
        .clearing     (clearing),
        .q_status     (q_status),
        .push         (push),
        .push_data    (push_data)
    );

    ssba_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    ssba_back #(
        .SLOTS            (SLOTS),
        .SECTORS_PER_SLOT (SECTORS_PER_SLOT),
        .CNT_W            (CNT_W)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .active_count   (active_count),
        .q_status       (q_status),
        .pop_data       (pop_data),
        .pop            (pop),
        .clearing       (clearing),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_slot_number  (m_slot_number),
        .m_first_sector (m_first_sector),
        .m_status       (m_status)
    );

endmodule
